// ===== src/slbe_pkg.sv =====
// Package for the segment LCD buffer engine: op codes, image geometry,
// segment tables and the controller/datapath command struct.
// No dependencies.
package slbe_pkg;

	// Command codes on the op port
	localparam logic [3:0] OP_DIGIT      = 4'd0;
	localparam logic [3:0] OP_ICON_ON    = 4'd1;
	localparam logic [3:0] OP_ICON_OFF   = 4'd2;
	localparam logic [3:0] OP_ICON_TOG   = 4'd3;
	localparam logic [3:0] OP_FAN_SELECT = 4'd4;
	localparam logic [3:0] OP_CLEAR      = 4'd5;
	localparam logic [3:0] OP_SET        = 4'd6;
	localparam logic [3:0] OP_PAIR       = 4'd7;
	localparam logic [3:0] OP_FLUSH      = 4'd8;
	localparam logic [3:0] OP_INIT       = 4'd9;

	// Icon codes
	localparam logic [2:0] ICON_FAN1 = 3'd1;
	localparam logic [2:0] ICON_FAN2 = 3'd3;
	localparam logic [2:0] ICON_FAN3 = 3'd6;
	localparam logic [2:0] ICON_ALL  = 3'd7;
	localparam int         NUM_ICONS = 7;

	localparam logic [1:0] FAN_NONE = 2'd3;

	// Image geometry: entry i holds controller address i+2
	localparam int         IMG_LEN   = 13;
	localparam int         NUM_POS   = 9;
	localparam logic [3:0] BEAT_HDR0 = 4'd0;
	localparam logic [3:0] BEAT_HDR1 = 4'd1;
	localparam logic [3:0] BEAT_LAST = 4'(IMG_LEN + 1);

	// Controller bytes
	localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
	localparam logic [7:0] CMD_ADDR_START = 8'hC2;
	localparam logic [7:0] DISP_CTRL_RST  = 8'h97;

	// Reciprocal of ten for an 8-bit value: (v * 205) >> 11
	localparam logic [7:0] RECIP10       = 8'd205;
	localparam int         RECIP10_SHIFT = 11;

	// Keep masks for the shared icon bit of each panel table
	localparam logic [7:0] KEEP_A = 8'h10;
	localparam logic [7:0] KEEP_B = 8'h08;
	localparam logic [7:0] KEEP_C = 8'h80;

	localparam logic [7:0] SEG_A [10] = '{8'hAF, 8'h06, 8'h6D, 8'h4F, 8'hC6,
		8'hCB, 8'hEB, 8'h0E, 8'hEF, 8'hCF};
	localparam logic [7:0] SEG_B [10] = '{8'hF5, 8'h60, 8'hB6, 8'hF2, 8'h63,
		8'hD3, 8'hD7, 8'h70, 8'hF7, 8'hF3};
	localparam logic [7:0] SEG_C [10] = '{8'h5F, 8'h06, 8'h6B, 8'h2F, 8'h36,
		8'h3D, 8'h7D, 8'h07, 8'h7F, 8'h3F};

	// Image entry of each digit position and of each icon
	localparam logic [3:0] POS_IDX [NUM_POS] = '{4'd8, 4'd7, 4'd3, 4'd2, 4'd10,
		4'd9, 4'd0, 4'd1, 4'd12};
	localparam logic [3:0] ICON_IDX [NUM_ICONS] = '{4'd8, 4'd7, 4'd3, 4'd2, 4'd0,
		4'd10, 4'd12};
	localparam logic [7:0] ICON_MASK [NUM_ICONS] = '{8'h10, 8'h10, 8'h10, 8'h10,
		8'h08, 8'h80, 8'h80};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAIR_TENS,
		ST_PAIR_UNITS,
		ST_FLUSH
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       accept;
		logic       pair_tens;
		logic       pair_units;
		logic       flush_beat;
		logic [3:0] beat;
	} dp_cmd_t;

	// New byte for a digit position, keeping the shared icon bit of old
	function automatic logic [7:0] digit_byte(input logic [3:0] pos,
		input logic [3:0] val, input logic [7:0] old);
		logic [7:0] pat;
		logic [7:0] keep;
		logic       blank;
		blank = (val > 4'd9);
		case (pos)
			4'd0, 4'd1, 4'd2, 4'd3: begin
				pat  = blank ? 8'h00 : SEG_A[val];
				keep = KEEP_A;
			end
			4'd6, 4'd7: begin
				pat  = blank ? 8'h00 : SEG_B[val];
				keep = KEEP_B;
			end
			default: begin
				pat  = blank ? 8'h00 : SEG_C[val];
				keep = KEEP_C;
			end
		endcase
		return pat | (old & keep);
	endfunction

endpackage

// ===== src/slbe_ctrl.sv =====
// Controller of the segment LCD buffer engine: command sequencing state
// machine and flush beat counter. Depends on slbe_pkg.
module slbe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [3:0]       op,
	output logic             busy,
	output slbe_pkg::dp_cmd_t cmd
);
	import slbe_pkg::*;

	state_t     state_q, state_n;
	logic [3:0] beat_q, beat_n;
	logic       accept;

	assign accept = start && !busy;

	// Next state and beat count
	always_comb begin
		state_n = state_q;
		beat_n  = beat_q;
		case (state_q)
			ST_IDLE: begin
				beat_n = '0;
				if (accept && op == OP_PAIR) begin
					state_n = ST_PAIR_TENS;
				end else if (accept && op == OP_FLUSH) begin
					state_n = ST_FLUSH;
				end
			end
			ST_PAIR_TENS: begin
				state_n = ST_PAIR_UNITS;
			end
			ST_PAIR_UNITS: begin
				state_n = ST_IDLE;
			end
			ST_FLUSH: begin
				beat_n = beat_q + 4'd1;
				if (beat_q == BEAT_LAST) begin
					state_n = ST_IDLE;
					beat_n  = '0;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath
	always_comb begin
		busy            = 1'b1;
		cmd.accept      = 1'b0;
		cmd.pair_tens   = 1'b0;
		cmd.pair_units  = 1'b0;
		cmd.flush_beat  = 1'b0;
		cmd.beat        = beat_q;
		case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_PAIR_TENS: begin
				cmd.pair_tens = 1'b1;
			end
			ST_PAIR_UNITS: begin
				cmd.pair_units = 1'b1;
			end
			ST_FLUSH: begin
				cmd.flush_beat = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			beat_q  <= '0;
		end else begin
			state_q <= state_n;
			beat_q  <= beat_n;
		end
	end

endmodule

// ===== src/slbe_dp.sv =====
// Datapath of the segment LCD buffer engine: display image register file,
// digit/icon update logic, pair splitter and output register. Depends on slbe_pkg.
module slbe_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  slbe_pkg::dp_cmd_t cmd,
	input  logic [3:0]        op,
	input  logic [3:0]        position,
	input  logic [3:0]        digit,
	input  logic [2:0]        icon,
	input  logic [1:0]        fan_number,
	input  logic [1:0]        pair_index,
	input  logic [7:0]        pair_value,
	input  logic              cfg_write,
	input  logic [7:0]        cfg_data,
	output logic              strobe,
	output logic [7:0]        out_byte,
	output logic              frame_start,
	output logic              frame_end,
	output logic              last
);
	import slbe_pkg::*;

	logic [7:0]  img_q [IMG_LEN];
	logic [7:0]  img_n [IMG_LEN];
	logic [7:0]  disp_ctrl_q;

	logic [1:0]  pair_idx_q;
	logic [3:0]  tens_q;
	logic [3:0]  units_q;
	logic [15:0] recip_prod;
	logic [4:0]  tens_full;
	logic [7:0]  tens_x10;
	logic [7:0]  units_full;

	logic        wr_en;
	logic [3:0]  wr_pos;
	logic [3:0]  wr_val;
	logic [3:0]  wr_idx;

	logic        strobe_q;
	logic [7:0]  out_byte_q;
	logic        frame_start_q;
	logic        frame_end_q;
	logic        last_q;

	// Split the pair value into tens and units
	assign recip_prod = pair_value * RECIP10;
	assign tens_full  = recip_prod[15:RECIP10_SHIFT];
	assign tens_x10   = {tens_full[4:0], 3'b000} + {2'b00, tens_full[4:0], 1'b0};
	assign units_full = pair_value - tens_x10;

	always_ff @(posedge clk) begin
		if (cmd.accept && op == OP_PAIR) begin
			pair_idx_q <= pair_index;
			tens_q     <= (tens_full > 5'd9) ? 4'hF : tens_full[3:0];
			units_q    <= units_full[3:0];
		end
	end

	// Select the digit write of this cycle
	always_comb begin
		wr_en  = 1'b0;
		wr_pos = position;
		wr_val = digit;
		if (cmd.accept && op == OP_DIGIT && position < 4'(NUM_POS)) begin
			wr_en = 1'b1;
		end else if (cmd.pair_tens) begin
			wr_en  = 1'b1;
			wr_pos = {1'b0, pair_idx_q, 1'b0};
			wr_val = tens_q;
		end else if (cmd.pair_units) begin
			wr_en  = 1'b1;
			wr_pos = {1'b0, pair_idx_q, 1'b1};
			wr_val = units_q;
		end
		wr_idx = (wr_pos < 4'(NUM_POS)) ? POS_IDX[wr_pos] : POS_IDX[0];
	end

	// Next image: icon ops, fill, digit write, rotate during flush
	always_comb begin
		img_n = img_q;
		if (cmd.accept) begin
			case (op)
				OP_ICON_ON, OP_ICON_OFF, OP_ICON_TOG: begin
					for (int k = 0; k < NUM_ICONS; k++) begin
						if (icon == ICON_ALL || icon == 3'(k)) begin
							if (op == OP_ICON_ON) begin
								img_n[ICON_IDX[k]] = img_n[ICON_IDX[k]] | ICON_MASK[k];
							end else if (op == OP_ICON_OFF) begin
								img_n[ICON_IDX[k]] = img_n[ICON_IDX[k]] & ~ICON_MASK[k];
							end else begin
								img_n[ICON_IDX[k]] = img_n[ICON_IDX[k]] ^ ICON_MASK[k];
							end
						end
					end
				end
				OP_FAN_SELECT: begin
					for (int k = 0; k < NUM_ICONS; k++) begin
						if (3'(k) == ICON_FAN1 || 3'(k) == ICON_FAN2 || 3'(k) == ICON_FAN3) begin
							img_n[ICON_IDX[k]] = img_n[ICON_IDX[k]] & ~ICON_MASK[k];
						end
					end
					case (fan_number)
						2'd0: img_n[ICON_IDX[ICON_FAN1]] =
							img_n[ICON_IDX[ICON_FAN1]] | ICON_MASK[ICON_FAN1];
						2'd1: img_n[ICON_IDX[ICON_FAN2]] =
							img_n[ICON_IDX[ICON_FAN2]] | ICON_MASK[ICON_FAN2];
						2'd2: img_n[ICON_IDX[ICON_FAN3]] =
							img_n[ICON_IDX[ICON_FAN3]] | ICON_MASK[ICON_FAN3];
						default: img_n[ICON_IDX[0]] = img_n[ICON_IDX[0]];
					endcase
				end
				OP_CLEAR: begin
					for (int i = 0; i < IMG_LEN; i++) begin
						img_n[i] = 8'h00;
					end
				end
				OP_SET: begin
					for (int i = 0; i < IMG_LEN; i++) begin
						img_n[i] = 8'hFF;
					end
				end
				default: begin
					img_n[0] = img_q[0];
				end
			endcase
		end
		if (wr_en) begin
			img_n[wr_idx] = digit_byte(wr_pos, wr_val, img_q[wr_idx]);
		end
		// Rotate one entry per image beat; a full pass over all IMG_LEN entries restores the order
		if (cmd.flush_beat && cmd.beat > BEAT_HDR1) begin
			for (int i = 0; i < IMG_LEN - 1; i++) begin
				img_n[i] = img_q[i + 1];
			end
			img_n[IMG_LEN - 1] = img_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IMG_LEN; i++) begin
				img_q[i] <= 8'h00;
			end
			disp_ctrl_q <= DISP_CTRL_RST;
		end else begin
			img_q <= img_n;
			if (cfg_write) begin
				disp_ctrl_q <= cfg_data;
			end
		end
	end

	// Output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.accept && op == OP_INIT) || cmd.flush_beat;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.accept && op == OP_INIT) begin
			out_byte_q    <= disp_ctrl_q;
			frame_start_q <= 1'b1;
			frame_end_q   <= 1'b1;
			last_q        <= 1'b1;
		end else if (cmd.flush_beat) begin
			case (cmd.beat)
				BEAT_HDR0: begin
					out_byte_q    <= CMD_DATA_WRITE;
					frame_start_q <= 1'b1;
					frame_end_q   <= 1'b1;
					last_q        <= 1'b0;
				end
				BEAT_HDR1: begin
					out_byte_q    <= CMD_ADDR_START;
					frame_start_q <= 1'b1;
					frame_end_q   <= 1'b0;
					last_q        <= 1'b0;
				end
				default: begin
					out_byte_q    <= img_q[0];
					frame_start_q <= 1'b0;
					frame_end_q   <= (cmd.beat == BEAT_LAST);
					last_q        <= (cmd.beat == BEAT_LAST);
				end
			endcase
		end
	end

	assign strobe      = strobe_q;
	assign out_byte    = out_byte_q;
	assign frame_start = frame_start_q;
	assign frame_end   = frame_end_q;
	assign last        = last_q;

endmodule

// ===== src/segment_lcd_buffer_engine.sv =====
// Top level of the segment LCD buffer engine: controller plus datapath.
// Depends on slbe_pkg, slbe_ctrl and slbe_dp.
//
// Usage:
//   Command channel: a command is taken at a clock edge with start high and
//   busy low. Digit, icon, fan, clear and set commands update the 13-byte
//   display image in place. A pair command splits its value when taken,
//   then writes the tens digit and then the units digit, with busy high
//   during both writes. A flush gives one beat per emitted byte, the image
//   bytes coming from entry 0 of the image while the image rotates once
//   round; busy stays high for every flush beat.
//   Result channel: each byte appears for one cycle with strobe high, in the
//   cycle after its beat; init gives one byte the cycle after it is taken, a
//   flush gives its first byte after the flush state and the output register,
//   then one byte per cycle. The receiver cannot stall; bytes are not held.
//   Config channel: cfg_data is written to the display-control register on
//   a transfer (cfg_valid and cfg_ready); cfg_ready is high while idle.
//   Reset clears the image to all zeros, sets display control to 0x97 and
//   returns the controller to idle with no strobe pending.
module segment_lcd_buffer_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [3:0] op,
	input  logic [3:0] position,
	input  logic [3:0] digit,
	input  logic [2:0] icon,
	input  logic [1:0] fan_number,
	input  logic [1:0] pair_index,
	input  logic [7:0] pair_value,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output logic       strobe,
	output logic [7:0] out_byte,
	output logic       frame_start,
	output logic       frame_end,
	output logic       last
);
	import slbe_pkg::*;

	dp_cmd_t cmd;

	assign cfg_ready = !busy;

	slbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.cmd    (cmd)
	);

	slbe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.position    (position),
		.digit       (digit),
		.icon        (icon),
		.fan_number  (fan_number),
		.pair_index  (pair_index),
		.pair_value  (pair_value),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.strobe      (strobe),
		.out_byte    (out_byte),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.last        (last)
	);

endmodule

// ===== src/slbe_checker.sv =====
// Port-level checker for the segment LCD buffer engine, bound to the top.
// Depends on slbe_pkg and segment_lcd_buffer_engine.
module slbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [3:0] op,
	input logic       strobe,
	input logic [7:0] out_byte,
	input logic       frame_start,
	input logic       frame_end,
	input logic       last
);
	import slbe_pkg::*;

	// A taken flush holds the command channel off
	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == OP_FLUSH |=> busy)
		else $error("flush taken but busy not raised");

	// A taken init gives its single byte in the next cycle
	a_init_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == OP_INIT |=> strobe && last && frame_start && frame_end)
		else $error("init byte missing or misframed");

	// The final byte of a command always closes a frame
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> frame_end)
		else $error("last byte without frame end");

	// An opening frame byte that does not close is the address byte
	a_addr_byte: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && frame_start && !frame_end |-> out_byte == CMD_ADDR_START)
		else $error("address start byte wrong");

	// The data-write byte is followed by the address byte
	a_hdr_seq: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && frame_start && frame_end && !last |=> strobe && out_byte == CMD_ADDR_START)
		else $error("flush header sequence broken");

endmodule

bind segment_lcd_buffer_engine slbe_checker u_slbe_checker (.*);

// ===== tb/sv/slbe_byte_checker.sv =====
`timescale 1ns / 100ps
// Checker for the segment LCD buffer engine. It keeps its own display image
// and control byte, works out every byte the engine must emit and compares.
// Depends on slbe_pkg for the op and icon codes.
module slbe_byte_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [3:0] op,
	input  logic [3:0] position,
	input  logic [3:0] digit,
	input  logic [2:0] icon,
	input  logic [1:0] fan_number,
	input  logic [1:0] pair_index,
	input  logic [7:0] pair_value,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       strobe,
	input  logic [7:0] out_byte,
	input  logic       frame_start,
	input  logic       frame_end,
	input  logic       last,
	output int         mismatches,
	output int         pending,
	output int         cmds_taken,
	output int         bytes_seen
);
	import slbe_pkg::*;

	localparam int         IMAGE_BYTES  = 13;
	localparam logic [7:0] LCD_WRITE    = 8'h40;
	localparam logic [7:0] LCD_ADDR2    = 8'hC2;
	localparam logic [7:0] CTRL_DEFAULT = 8'h97;

	// Segment patterns of the three panel tables
	localparam logic [7:0] PANEL_A [10] = '{8'hAF, 8'h06, 8'h6D, 8'h4F, 8'hC6,
		8'hCB, 8'hEB, 8'h0E, 8'hEF, 8'hCF};
	localparam logic [7:0] PANEL_B [10] = '{8'hF5, 8'h60, 8'hB6, 8'hF2, 8'h63,
		8'hD3, 8'hD7, 8'h70, 8'hF7, 8'hF3};
	localparam logic [7:0] PANEL_C [10] = '{8'h5F, 8'h06, 8'h6B, 8'h2F, 8'h36,
		8'h3D, 8'h7D, 8'h07, 8'h7F, 8'h3F};

	// Image entry (controller address minus two) of positions and icons
	localparam int         DIGIT_ENTRY [9] = '{8, 7, 3, 2, 10, 9, 0, 1, 12};
	localparam int         ICON_ENTRY  [7] = '{8, 7, 3, 2, 0, 10, 12};
	localparam logic [7:0] ICON_BIT    [7] = '{8'h10, 8'h10, 8'h10, 8'h10,
		8'h08, 8'h80, 8'h80};
	localparam logic [2:0] FAN_ICON    [3] = '{ICON_FAN1, ICON_FAN2, ICON_FAN3};

	typedef enum {ACT_SET, ACT_CLEAR, ACT_FLIP} icon_act_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fs;
		logic       fe;
		logic       lst;
	} lcd_byte_t;

	logic [7:0] image [IMAGE_BYTES];
	logic [7:0] ctrl_byte;
	lcd_byte_t  lcd_bytes_due [$];

	// Write a digit pattern, keeping the icon bit that shares the byte
	function automatic void place_digit(input int pos, input int val);
		int         entry;
		logic [7:0] seg;
		logic [7:0] keep;
		if (pos > 8) return;
		entry = DIGIT_ENTRY[pos];
		if (pos <= 3) begin
			seg  = (val < 10) ? PANEL_A[val] : 8'h00;
			keep = 8'h10;
		end else if (pos == 6 || pos == 7) begin
			seg  = (val < 10) ? PANEL_B[val] : 8'h00;
			keep = 8'h08;
		end else begin
			seg  = (val < 10) ? PANEL_C[val] : 8'h00;
			keep = 8'h80;
		end
		image[entry] = seg | (image[entry] & keep);
	endfunction

	function automatic void touch_icon(input int which, input icon_act_t act);
		for (int k = 0; k < 7; k++) begin
			if (which == ICON_ALL || which == k) begin
				case (act)
					ACT_SET:   image[ICON_ENTRY[k]] = image[ICON_ENTRY[k]] | ICON_BIT[k];
					ACT_CLEAR: image[ICON_ENTRY[k]] = image[ICON_ENTRY[k]] & ~ICON_BIT[k];
					default:   image[ICON_ENTRY[k]] = image[ICON_ENTRY[k]] ^ ICON_BIT[k];
				endcase
			end
		end
	endfunction

	// Update the image for one command and queue the bytes it emits
	function automatic void apply_command();
		case (op)
			OP_DIGIT:    place_digit(int'(position), int'(digit));
			OP_ICON_ON:  touch_icon(int'(icon), ACT_SET);
			OP_ICON_OFF: touch_icon(int'(icon), ACT_CLEAR);
			OP_ICON_TOG: touch_icon(int'(icon), ACT_FLIP);
			OP_FAN_SELECT: begin
				for (int k = 0; k < 3; k++)
					touch_icon(int'(FAN_ICON[k]), (int'(fan_number) == k) ? ACT_SET : ACT_CLEAR);
			end
			OP_CLEAR, OP_SET: begin
				for (int i = 0; i < IMAGE_BYTES; i++)
					image[i] = (op == OP_CLEAR) ? 8'h00 : 8'hFF;
			end
			OP_PAIR: begin
				place_digit(2 * int'(pair_index), int'(pair_value) / 10);
				place_digit(2 * int'(pair_index) + 1, int'(pair_value) % 10);
			end
			OP_FLUSH: begin
				lcd_bytes_due.push_back('{LCD_WRITE, 1'b1, 1'b1, 1'b0});
				lcd_bytes_due.push_back('{LCD_ADDR2, 1'b1, 1'b0, 1'b0});
				for (int i = 0; i < IMAGE_BYTES; i++)
					lcd_bytes_due.push_back('{image[i], 1'b0, i == IMAGE_BYTES - 1,
						i == IMAGE_BYTES - 1});
			end
			OP_INIT: lcd_bytes_due.push_back('{ctrl_byte, 1'b1, 1'b1, 1'b1});
			default: ;
		endcase
	endfunction

	task automatic flag(input string why, input lcd_byte_t want, input lcd_byte_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected %h fs=%b fe=%b last=%b, got %h fs=%b fe=%b last=%b",
				$time, why, want.data, want.fs, want.fe, want.lst,
				got.data, got.fs, got.fe, got.lst);
	endtask

	// Compare first, then predict: a command never emits on its own edge
	always @(posedge clk or negedge arst_n) begin : watch
		lcd_byte_t got;
		lcd_byte_t want;
		if (!arst_n) begin
			for (int i = 0; i < IMAGE_BYTES; i++)
				image[i] = 8'h00;
			ctrl_byte = CTRL_DEFAULT;
			lcd_bytes_due.delete();
			mismatches = 0;
			pending    = 0;
			cmds_taken = 0;
			bytes_seen = 0;
		end else begin
			if (strobe) begin
				bytes_seen++;
				got = '{out_byte, frame_start, frame_end, last};
				if (lcd_bytes_due.size() == 0) begin
					flag("unexpected byte", '0, got);
				end else begin
					want = lcd_bytes_due.pop_front();
					if (got.data !== want.data || got.fs !== want.fs ||
						got.fe !== want.fe || got.lst !== want.lst)
						flag("byte mismatch", want, got);
				end
			end
			if (start && !busy) begin
				cmds_taken++;
				apply_command();
			end
			if (cfg_valid && cfg_ready)
				ctrl_byte = cfg_data;
			pending = lcd_bytes_due.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the segment LCD buffer engine testbench: clock, reset, command and
// control-register stimulus, verdict. Depends on slbe_pkg, the engine RTL
// and slbe_byte_checker.
module tb_top;
	import slbe_pkg::*;

	localparam logic [2:0] ICON_CLOCK = 3'd0;
	localparam logic [2:0] ICON_LIGHT = 3'd5;
	localparam logic [3:0] OP_SPARE   = 4'hF;
	localparam int         RAND_PHASES = 4;
	localparam int         PHASE_ITEMS = 46;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [3:0] op;
	logic [3:0] position;
	logic [3:0] digit;
	logic [2:0] icon;
	logic [1:0] fan_number;
	logic [1:0] pair_index;
	logic [7:0] pair_value;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;
	logic       strobe;
	logic [7:0] out_byte;
	logic       frame_start;
	logic       frame_end;
	logic       last;

	int mismatches;
	int pending;
	int cmds_taken;
	int bytes_seen;
	int ctrl_writes;
	bit no_idle;

	segment_lcd_buffer_engine i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.position(position), .digit(digit), .icon(icon), .fan_number(fan_number),
		.pair_index(pair_index), .pair_value(pair_value), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data), .strobe(strobe),
		.out_byte(out_byte), .frame_start(frame_start), .frame_end(frame_end),
		.last(last)
	);

	slbe_byte_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.position(position), .digit(digit), .icon(icon), .fan_number(fan_number),
		.pair_index(pair_index), .pair_value(pair_value), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data), .strobe(strobe),
		.out_byte(out_byte), .frame_start(frame_start), .frame_end(frame_end),
		.last(last), .mismatches(mismatches), .pending(pending),
		.cmds_taken(cmds_taken), .bytes_seen(bytes_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly back to back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one command and hold it until the engine takes it
	task automatic issue(input logic [3:0] c_op, input logic [3:0] c_pos,
		input logic [3:0] c_dig, input logic [2:0] c_icon, input logic [1:0] c_fan,
		input logic [1:0] c_pidx, input logic [7:0] c_pval);
		int idle;
		idle = pick_gap();
		if (idle > 0) begin
			start = 1'b0;
			repeat (idle) @(negedge clk);
		end
		op         = c_op;
		position   = c_pos;
		digit      = c_dig;
		icon       = c_icon;
		fan_number = c_fan;
		pair_index = c_pidx;
		pair_value = c_pval;
		start      = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Drain all output, let a trailing pair finish, then do one register transfer
	task automatic write_ctrl(input logic [7:0] value);
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = 8'($urandom);
		ctrl_writes++;
	endtask

	// Random command: mostly image updates with in-range fields, some flushes
	task automatic random_item();
		int         r;
		logic [3:0] c_op;
		logic [3:0] c_pos;
		logic [3:0] c_dig;
		r = $urandom_range(0, 99);
		if (r < 22)      c_op = OP_DIGIT;
		else if (r < 28) c_op = OP_ICON_ON;
		else if (r < 34) c_op = OP_ICON_OFF;
		else if (r < 40) c_op = OP_ICON_TOG;
		else if (r < 47) c_op = OP_FAN_SELECT;
		else if (r < 50) c_op = OP_CLEAR;
		else if (r < 53) c_op = OP_SET;
		else if (r < 70) c_op = OP_PAIR;
		else if (r < 85) c_op = OP_FLUSH;
		else if (r < 93) c_op = OP_INIT;
		else             c_op = 4'($urandom_range(int'(OP_INIT) + 1, int'(OP_SPARE)));
		c_pos = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
		c_dig = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15));
		issue(c_op, c_pos, c_dig, 3'($urandom), 2'($urandom), 2'($urandom), 8'($urandom));
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		op          = OP_DIGIT;
		position    = 4'd0;
		digit       = 4'd0;
		icon        = ICON_CLOCK;
		fan_number  = FAN_NONE;
		pair_index  = 2'd0;
		pair_value  = 8'd0;
		cfg_valid   = 1'b0;
		cfg_data    = 8'h00;
		ctrl_writes = 0;
		no_idle     = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset image and control byte, every op, blanking and
		// out-of-range cases, shared icon bits kept under digits
		issue(OP_INIT,       4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_FLUSH,      4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_SET,        4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_DIGIT,      4'd0,  4'd8,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_DIGIT,      4'd6,  4'd0,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_DIGIT,      4'd4,  4'd9,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_DIGIT,      4'd8,  4'd15, ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_DIGIT,      4'd7,  4'd10, ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_DIGIT,      4'd15, 4'd3,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_FLUSH,      4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_CLEAR,      4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_ICON_ON,    4'd0,  4'd0,  ICON_ALL,   2'd0,     2'd0, 8'd0);
		issue(OP_ICON_TOG,   4'd0,  4'd0,  ICON_LIGHT, 2'd0,     2'd0, 8'd0);
		issue(OP_ICON_OFF,   4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_FAN_SELECT, 4'd0,  4'd0,  ICON_CLOCK, 2'd1,     2'd0, 8'd0);
		issue(OP_FLUSH,      4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_FAN_SELECT, 4'd0,  4'd0,  ICON_CLOCK, FAN_NONE, 2'd0, 8'd0);
		issue(OP_PAIR,       4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd3, 8'd255);
		issue(OP_PAIR,       4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);
		issue(OP_PAIR,       4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd2, 8'd99);
		issue(OP_PAIR,       4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd1, 8'd100);
		issue(OP_SPARE,      4'd3,  4'd3,  ICON_ALL,   2'd3,     2'd3, 8'd255);
		issue(OP_FLUSH,      4'd0,  4'd0,  ICON_CLOCK, 2'd0,     2'd0, 8'd0);

		// Random phases, each under its own control byte; one without idling
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0:       write_ctrl(8'h00);
				1:       write_ctrl(8'hFF);
				default: write_ctrl(8'($urandom));
			endcase
			no_idle = (ph == 2);
			issue(OP_INIT, 4'd0, 4'd0, ICON_CLOCK, 2'd0, 2'd0, 8'd0);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item();
		end
		start = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		$display("Engine took %0d commands and emitted %0d bytes, all checked,",
			cmds_taken, bytes_seen);
		$display("under the reset control byte and %0d written ones.", ctrl_writes);
		if (mismatches == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
